FILE: rtl/core/adamwu_pkg.sv
// ----------------------------------------------------------------------------
// adamwu_pkg
// Shared sizes, register codes, reset values and unit request types of the
// Adam weight update block.
// ----------------------------------------------------------------------------
package adamwu_pkg;

    localparam int WEIGHT_COUNT = 1024;
    localparam int BIAS_COUNT   = 64;
    localparam int MEM_DEPTH    = WEIGHT_COUNT + BIAS_COUNT;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int MEM_W        = 96;

    localparam int INDEX_W   = 10;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Divider sizes: a 96-bit dividend over a divisor of up to 41 bits.
    localparam int NUM_W = 96;
    localparam int DEN_W = 41;

    localparam logic [DATA_W-1:0] LR_RESET    = 32'd4294967;
    localparam logic [DATA_W-1:0] BETA1_RESET = 32'd3865470566;
    localparam logic [DATA_W-1:0] BETA2_RESET = 32'd4290672329;
    localparam logic [DATA_W-1:0] EPS_RESET   = 32'd43;

    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
    localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 2'd0,
        CFG_BETA_ONE      = 2'd1,
        CFG_BETA_TWO      = 2'd2,
        CFG_EPSILON       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

endpackage

FILE: rtl/core/adamwu_if.sv
// ----------------------------------------------------------------------------
// adamwu_if
// Valid/ready channels of the Adam weight update block: parameter elements
// in, updated values out.
// ----------------------------------------------------------------------------
interface adamwu_in_if
    import adamwu_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value_in;
    logic signed [DATA_W-1:0]  gradient;
    logic                      pass_start;

    modport source (output valid, kind, index, value_in, gradient, pass_start,
                    input ready);
    modport sink   (input valid, kind, index, value_in, gradient, pass_start,
                    output ready);
endinterface

interface adamwu_out_if
    import adamwu_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  value_out;
    logic                      no_step_error;

    modport source (output valid, value_out, no_step_error, input ready);
    modport sink   (input valid, value_out, no_step_error, output ready);
endinterface

FILE: rtl/core/adamwu_ram.sv
// ----------------------------------------------------------------------------
// adamwu_ram
// Moment store: one write port, one read port, registered read data.
// Each entry holds the second moment above the first moment.
// ----------------------------------------------------------------------------
module adamwu_ram
    import adamwu_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [MEM_AW-1:0] waddr,
    input  logic [MEM_W-1:0]  wdata,
    input  logic              re,
    input  logic [MEM_AW-1:0] raddr,
    output logic [MEM_W-1:0]  rdata
);

    logic [MEM_W-1:0] mem [MEM_DEPTH];
    logic [MEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/adamwu_div.sv
// ----------------------------------------------------------------------------
// adamwu_div
// Restoring divider, one quotient bit per cycle over the full dividend.
// ----------------------------------------------------------------------------
module adamwu_div
    import adamwu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] dq_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dq_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient bits shift in behind the dividend bits as they leave.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

FILE: rtl/core/adamwu_sqrt.sv
// ----------------------------------------------------------------------------
// adamwu_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module adamwu_sqrt
    import adamwu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    localparam int CNT_W = $clog2(33);

    logic [63:0]      x_reg;
    logic [33:0]      rem_reg;
    logic [31:0]      root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [35:0] shifted;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        shifted = {rem_reg, x_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        diff    = shifted - trial;
        ge      = (shifted >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(32);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= ge ? diff[33:0] : shifted[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

FILE: rtl/core/adam_weight_update.sv
// ----------------------------------------------------------------------------
// adam_weight_update
// Adam optimiser update of one weight or bias element per request.
// ----------------------------------------------------------------------------
// Requests enter on in_ch (kind, index, value_in, gradient, pass_start) and
// each one yields exactly one result on out_ch (value_out, no_step_error).
// Registers are written through write_enable / write_index / write_data. The
// user must write them only while the block is idle; it does not enforce it.
// Elements are handled one at a time. An element that updates its moments
// goes, after the power states of a weight pass start, through a check
// state, the states on the shared multiplier, three passes through the
// shared restoring divider (m_hat, v_hat and the step) with the square root
// unit between the second and third, more multiplier states and a result
// state. A zero denominator skips the last division. Elements that pass
// straight through go from the check state to the finish. The next request
// can be taken in the cycle after a result has been loaded.
// After reset all 1088 entries of the moment memory are cleared, one entry a
// cycle; no request is taken during that pass, register writes are.
// A finished result sits in an output register; a new request is taken while
// it waits, and the block holds its next result until the receiver takes the
// earlier one.
// ----------------------------------------------------------------------------
module adam_weight_update
    import adamwu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    adamwu_in_if.sink            in_ch,
    adamwu_out_if.source         out_ch,
    input  logic                 write_enable,
    input  logic [CFG_IDX_W-1:0] write_index,
    input  logic [DATA_W-1:0]    write_data
);

    typedef enum logic [21:0] {
        S_CLEAR  = 22'h000001,
        S_IDLE   = 22'h000002,
        S_POW1   = 22'h000004,
        S_POW2   = 22'h000008,
        S_CHECK  = 22'h000010,
        S_M1     = 22'h000020,
        S_M2     = 22'h000040,
        S_M3     = 22'h000080,
        S_M4     = 22'h000100,
        S_M5     = 22'h000200,
        S_M6     = 22'h000400,
        S_M7     = 22'h000800,
        S_M8     = 22'h001000,
        S_DIV1   = 22'h002000,
        S_DIV2   = 22'h004000,
        S_SQRT   = 22'h008000,
        S_L1     = 22'h010000,
        S_L2     = 22'h020000,
        S_L3     = 22'h040000,
        S_DIV3   = 22'h080000,
        S_RES    = 22'h100000,
        S_FINISH = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] lr_reg, b1_reg, b2_reg, eps_reg;
    logic [32:0]       p1_reg, p2_reg;
    logic              step_seen_reg;
    logic              adv_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic              out_valid_reg;

    logic              in_range_reg;
    logic [MEM_AW-1:0] addr_reg;
    logic signed [DATA_W-1:0] val_reg, g_reg;
    logic signed [67:0] prod_reg, pm_reg;
    logic [31:0]       m_new_reg;
    logic [63:0]       va_reg, v_new_reg, mhat_reg;
    logic [31:0]       g2lo_reg;
    logic [DEN_W-1:0]  d_reg;
    logic [NUM_W-1:0]  acc_reg;
    logic [33:0]       step_reg;
    logic [31:0]       result_reg;
    logic              err_reg;
    logic [31:0]       value_out_reg;
    logic              err_out_reg;

    logic              in_accept;
    logic              out_load;
    logic              seen;
    logic              in_range_c;
    logic [MEM_AW-1:0] raddr_c;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [MEM_W-1:0]  ram_wdata;
    logic [MEM_W-1:0]  ram_rdata;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_c;
    logic [32:0]       cb2, c1, c2;
    logic [31:0]       gmag, mmag, m_cur;
    logic [63:0]       v_cur, v_new_c, vhat_c;
    logic signed [67:0] msum;
    logic [NUM_W-1:0]  num_c;
    logic [33:0]       step_c;
    logic signed [35:0] res_wide;
    logic [31:0]       res_sat;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    sqrt_req_t         sqrt_req;
    sqrt_rsp_t         sqrt_rsp;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign out_load    = (state_reg == S_FINISH) && (!out_valid_reg || out_ch.ready);
    assign seen        = step_seen_reg || adv_reg;

    always_comb
    begin
        if (in_ch.kind)
        begin
            in_range_c = (32'(in_ch.index) < BIAS_COUNT);
            raddr_c    = MEM_AW'(WEIGHT_COUNT) + MEM_AW'(in_ch.index);
        end
        else
        begin
            in_range_c = (32'(in_ch.index) < WEIGHT_COUNT);
            raddr_c    = MEM_AW'(in_ch.index);
        end
        if (!in_range_c)
        begin
            raddr_c = '0;
        end
    end

    always_comb
    begin
        cb2   = ONE_Q32 - {1'b0, b2_reg};
        c1    = ONE_Q32 - p1_reg;
        c2    = ONE_Q32 - p2_reg;
        gmag  = g_reg[31] ? (32'd0 - g_reg) : g_reg;
        mmag  = m_new_reg[31] ? (32'd0 - m_new_reg) : m_new_reg;
        m_cur = ram_rdata[31:0];
        v_cur = ram_rdata[95:32];
        msum  = pm_reg - prod_reg + {{4{g_reg[31]}}, g_reg, 32'd0};
        v_new_c = va_reg + {32'd0, prod_reg[63:32]};
        // v_hat saturates when the quotient outgrows 64 bits.
        vhat_c  = (|div_rsp.quotient[95:64]) ? '1 : div_rsp.quotient[63:0];
        num_c   = acc_reg + {32'd0, prod_reg[63:0]};
        step_c  = ((|div_rsp.quotient[95:34]) || (div_rsp.quotient[33:0] > STEP_CAP))
                  ? STEP_CAP : div_rsp.quotient[33:0];
        if (m_new_reg[31])
        begin
            res_wide = {{4{val_reg[31]}}, val_reg} + {2'b00, step_reg};
        end
        else
        begin
            res_wide = {{4{val_reg[31]}}, val_reg} - {2'b00, step_reg};
        end
        if (res_wide > 36'sd2147483647)
        begin
            res_sat = 32'h7FFF_FFFF;
        end
        else if (res_wide < -36'sd2147483648)
        begin
            res_sat = 32'h8000_0000;
        end
        else
        begin
            res_sat = res_wide[31:0];
        end
    end

    // Shared multiplier operands; the product is registered every cycle and
    // used by the following state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_POW1:
            begin
                mul_a = {2'b00, p1_reg[31:0]};
                mul_b = {2'b00, b1_reg};
            end
            S_POW2:
            begin
                mul_a = {2'b00, p2_reg[31:0]};
                mul_b = {2'b00, b2_reg};
            end
            S_M1:
            begin
                mul_a = {2'b00, b1_reg};
                mul_b = {{2{m_cur[31]}}, m_cur};
            end
            S_M2:
            begin
                mul_a = {2'b00, b1_reg};
                mul_b = {{2{g_reg[31]}}, g_reg};
            end
            S_M3:
            begin
                mul_a = {2'b00, v_cur[63:32]};
                mul_b = {2'b00, b2_reg};
            end
            S_M4:
            begin
                mul_a = {2'b00, v_cur[31:0]};
                mul_b = {2'b00, b2_reg};
            end
            S_M5:
            begin
                mul_a = {2'b00, gmag};
                mul_b = {2'b00, gmag};
            end
            S_M6:
            begin
                mul_a = {2'b00, prod_reg[63:32]};
                mul_b = {1'b0, cb2};
            end
            S_M7:
            begin
                mul_a = {2'b00, g2lo_reg};
                mul_b = {1'b0, cb2};
            end
            S_L1:
            begin
                mul_a = {2'b00, mhat_reg[63:32]};
                mul_b = {2'b00, lr_reg};
            end
            S_L2:
            begin
                mul_a = {2'b00, mhat_reg[31:0]};
                mul_b = {2'b00, lr_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    always_comb
    begin
        div_req  = '0;
        sqrt_req = '0;
        case (state_reg)
            S_M8:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {32'd0, mmag, 32'd0};
                div_req.divisor  = DEN_W'(c1);
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {v_new_reg, 32'd0};
                    div_req.divisor  = DEN_W'(c2);
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    sqrt_req.start    = 1'b1;
                    sqrt_req.radicand = vhat_c;
                end
            end
            S_L3:
            begin
                if (d_reg != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = num_c;
                    div_req.divisor  = d_reg;
                end
            end
            default:
            begin
                div_req  = '0;
                sqrt_req = '0;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {v_new_c, m_new_reg};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_M8)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (!in_ch.kind && in_ch.pass_start) ? S_POW1 : S_CHECK;
                end
            end
            S_POW1:  state_next = S_POW2;
            S_POW2:  state_next = S_CHECK;
            S_CHECK: state_next = (seen && in_range_reg) ? S_M1 : S_FINISH;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = S_M6;
            S_M6:    state_next = S_M7;
            S_M7:    state_next = S_M8;
            S_M8:    state_next = S_DIV1;
            S_DIV1:  state_next = div_rsp.done ? S_DIV2 : S_DIV1;
            S_DIV2:  state_next = div_rsp.done ? S_SQRT : S_DIV2;
            S_SQRT:  state_next = sqrt_rsp.done ? S_L1 : S_SQRT;
            S_L1:    state_next = S_L2;
            S_L2:    state_next = S_L3;
            S_L3:    state_next = (d_reg == '0) ? S_RES : S_DIV3;
            S_DIV3:  state_next = div_rsp.done ? S_RES : S_DIV3;
            S_RES:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lr_reg        <= LR_RESET;
            b1_reg        <= BETA1_RESET;
            b2_reg        <= BETA2_RESET;
            eps_reg       <= EPS_RESET;
            p1_reg        <= ONE_Q32;
            p2_reg        <= ONE_Q32;
            step_seen_reg <= 1'b0;
            adv_reg       <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (write_enable)
            begin
                case (write_index)
                    CFG_LEARNING_RATE: lr_reg  <= write_data;
                    CFG_BETA_ONE:      b1_reg  <= write_data;
                    CFG_BETA_TWO:      b2_reg  <= write_data;
                    CFG_EPSILON:       eps_reg <= write_data;
                    default:           lr_reg  <= lr_reg;
                endcase
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
            if (in_accept)
            begin
                adv_reg <= !in_ch.kind && in_ch.pass_start;
            end
            // A power of exactly one scales to beta itself.
            if (state_reg == S_POW2)
            begin
                p1_reg <= p1_reg[32] ? {1'b0, b1_reg} : {1'b0, prod_reg[63:32]};
            end
            if ((state_reg == S_CHECK) && adv_reg)
            begin
                p2_reg        <= p2_reg[32] ? {1'b0, b2_reg} : {1'b0, prod_reg[63:32]};
                step_seen_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_c;
        if (in_accept)
        begin
            in_range_reg <= in_range_c;
            addr_reg     <= raddr_c;
            val_reg      <= in_ch.value_in;
            g_reg        <= in_ch.gradient;
        end
        case (state_reg)
            S_CHECK:
            begin
                result_reg <= val_reg;
                err_reg    <= !seen;
            end
            S_M2:   pm_reg    <= prod_reg;
            S_M3:   m_new_reg <= msum[63:32];
            S_M4:   va_reg    <= prod_reg[63:0];
            S_M5:   va_reg    <= va_reg + {32'd0, prod_reg[63:32]};
            S_M6:   g2lo_reg  <= prod_reg[31:0];
            S_M7:   va_reg    <= va_reg + prod_reg[63:0];
            S_M8:   v_new_reg <= v_new_c;
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    mhat_reg <= div_rsp.quotient[63:0];
                end
            end
            S_SQRT:
            begin
                if (sqrt_rsp.done)
                begin
                    d_reg <= {1'b0, sqrt_rsp.root, 8'd0} + {9'd0, eps_reg};
                end
            end
            S_L2:   acc_reg <= {prod_reg[63:0], 32'd0};
            S_L3:
            begin
                if (d_reg == '0)
                begin
                    step_reg <= '0;
                end
            end
            S_DIV3:
            begin
                if (div_rsp.done)
                begin
                    step_reg <= step_c;
                end
            end
            S_RES:  result_reg <= res_sat;
            default:
            begin
                pm_reg <= pm_reg;
            end
        endcase
        if (out_load)
        begin
            value_out_reg <= result_reg;
            err_out_reg   <= err_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.value_out     = value_out_reg;
    assign out_ch.no_step_error = err_out_reg;

    adamwu_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (raddr_c),
        .rdata (ram_rdata)
    );

    adamwu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    adamwu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

endmodule
